// ===== design/kdm_pkg.sv =====
// Package for the key debounce and multi-click block.
// Holds the timer width, phase encoding, register indexes and reset values.
// No dependencies.
package kdm_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int COUNT_W     = 3;

    localparam logic [COUNT_W-1:0] CLICK_MAX    = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] CLICK_DOUBLE = COUNT_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP  = CFG_IDX_W'(2);

    localparam logic [CFG_WIDTH-1:0] RST_DEBOUNCE   = CFG_WIDTH'(2);
    localparam logic [CFG_WIDTH-1:0] RST_LONG_PRESS = CFG_WIDTH'(100);
    localparam logic [CFG_WIDTH-1:0] RST_CLICK_GAP  = CFG_WIDTH'(30);

    typedef logic [TIMER_WIDTH-1:0] t_timer;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_DEBOUNCE = 4'b0010,
        PH_PRESSED  = 4'b0100,
        PH_LONG     = 4'b1000
    } t_phase;

    // Cuts or zero-extends a register value to the timer width.
    function automatic t_timer timer_load(input logic [CFG_WIDTH-1:0] v);
        logic [CFG_WIDTH+TIMER_WIDTH-1:0] ext;
        ext = {{TIMER_WIDTH{1'b0}}, v};
        return ext[TIMER_WIDTH-1:0];
    endfunction

endpackage

// ===== design/key_debounce_multiclick_top.sv =====
// Top level of the key debounce, long-press and multi-click detector.
// Depends on kdm_pkg.
//
// Each transfer on the input channel is one scan tick with the sampled key level, and each
// produces exactly one result, which the output register holds from the next cycle. The block
// takes one tick every clock cycle while the receiver is ready: the phase machine, the shared
// down counter and the click count are updated by a single pass of logic at the input
// transfer, and the result sits in an output register. A new tick enters in any cycle in which
// that register is empty or its result is taken, so ticks flow back to back while the receiver
// is ready, and the input stalls for as long as a result waits. Configuration writes take effect
// at once and should only be made while no result is pending.
module key_debounce_multiclick_top
    import kdm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_key_pressed,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_long_press,
    output logic [COUNT_W-1:0]   o_clicks_done,
    output logic                 o_double_click
);

    logic [CFG_WIDTH-1:0] r_debounce;
    logic [CFG_WIDTH-1:0] r_long_press;
    logic [CFG_WIDTH-1:0] r_click_gap;

    t_phase             r_phase, n_phase;
    t_timer             r_timer, n_timer;
    logic [COUNT_W-1:0] r_clicks, n_clicks;

    logic               r_out_valid;
    logic               r_long_out;
    logic [COUNT_W-1:0] r_done_out;
    logic               r_double_out;

    logic               n_long;
    logic [COUNT_W-1:0] n_done;
    logic               w_in_fire;
    t_timer             w_dec;
    t_timer             w_deb_load;

    assign o_ready   = !r_out_valid || i_ready;
    assign w_in_fire = i_valid && o_ready;

    assign w_dec      = (r_timer != '0) ? r_timer - t_timer'(1) : r_timer;
    assign w_deb_load = timer_load(r_debounce);

    always_comb begin
        n_phase  = r_phase;
        n_timer  = w_dec;
        n_clicks = r_clicks;
        n_long   = 1'b0;
        n_done   = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (!i_key_pressed) begin
                    if (r_clicks != '0 && (w_dec == '0 || r_clicks >= CLICK_MAX)) begin
                        n_done   = r_clicks;
                        n_clicks = '0;
                    end
                end else if (w_deb_load == '0) begin
                    n_timer = timer_load(r_long_press);
                    n_phase = PH_PRESSED;
                end else begin
                    n_timer = w_deb_load;
                    n_phase = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (!i_key_pressed) begin
                    n_phase = PH_IDLE;
                end else if (w_dec == '0) begin
                    n_timer = timer_load(r_long_press);
                    n_phase = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (!i_key_pressed) begin
                    n_phase = PH_IDLE;
                    if (r_clicks < CLICK_MAX) begin
                        n_clicks = r_clicks + COUNT_W'(1);
                    end
                    n_timer = timer_load(r_click_gap);
                end else if (w_dec == '0) begin
                    n_phase  = PH_LONG;
                    n_clicks = '0;
                    n_long   = 1'b1;
                end
            end
            PH_LONG: begin
                if (!i_key_pressed) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= RST_DEBOUNCE;
            r_long_press <= RST_LONG_PRESS;
            r_click_gap  <= RST_CLICK_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                REG_LONG_PRESS: r_long_press <= i_cfg_data;
                REG_CLICK_GAP:  r_click_gap  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_clicks    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_phase  <= n_phase;
                r_timer  <= n_timer;
                r_clicks <= n_clicks;
            end
            if (w_in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_long_out   <= n_long;
            r_done_out   <= n_done;
            r_double_out <= (n_done == CLICK_DOUBLE);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_long_press   = r_long_out;
    assign o_clicks_done  = r_done_out;
    assign o_double_click = r_double_out;

    // A long-press event never closes a click sequence on the same tick.
    a_long_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_long_press) |-> (o_clicks_done == '0))
        else $error("long press reported together with a click total");

    // The double-click flag matches a reported total of two.
    a_double_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_double_click == (o_clicks_done == CLICK_DOUBLE)))
        else $error("double-click flag disagrees with click total");

    // The pending click count saturates.
    a_clicks_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clicks <= CLICK_MAX)
        else $error("click count above its maximum");

    // A long-press event leaves the machine in the long-held phase with no clicks pending.
    a_long_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && n_long) |=> (r_phase == PH_LONG && r_clicks == '0))
        else $error("long press did not enter the long-held phase");

    // Reporting a sequence clears the pending count.
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && n_done != '0) |=> (r_clicks == '0))
        else $error("click count not cleared after a finished sequence");

endmodule
